FILE: sv/fccr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fccr_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned CHUNK_BYTES  = 512;
  localparam int unsigned COUNT_W      = 10;
  localparam int unsigned CSEC_W       = 7;

  localparam logic [31:0] CLUSTER_MASK = 32'h0FFF_FFFF;
  localparam logic [COUNT_W-1:0] BEAT_MAX =
    COUNT_W'((CHUNK_BYTES < SECTOR_BYTES) ? CHUNK_BYTES : SECTOR_BYTES);

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_READ  = 2'd1,
    OP_FAT   = 2'd2,
    OP_DONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_OPENED  = 3'd0,
    K_FATREQ  = 3'd1,
    K_DATAREQ = 3'd2,
    K_DONE    = 3'd3,
    K_ERROR   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READY = 2'd1,
    PH_FAT   = 2'd2,
    PH_DATA  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_SPC = 2'd0,
    REG_FDS = 2'd1,
    REG_FAT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] first_cluster;
    logic [31:0] file_length;
    logic [31:0] fat_word;
    logic        io_ok;
  } in_item_t;

  typedef struct packed {
    kind_e        kind;
    logic [31:0]  sector_number;
    logic [8:0]   entry_offset;
    logic [9:0]   byte_count;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/fat_cluster_chain_reader_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_data_i (fccr_pkg::in_item_t)
// out       output     out_valid_o/out_ready_i out_data_o (fccr_pkg::out_item_t)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Every beat gives one result, registered and shown the cycle after acceptance.
// The path is one 32x8 multiply for the data sector address plus two adds.
// in_ready_o stays high while the result register is empty or being drained,
// so beats flow back to back; a stalled output holds the input off.
// Reset clears the walker state; config resets to one sector per cluster.
module fat_cluster_chain_reader_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire fccr_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output fccr_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  import fccr_pkg::*;

  logic [7:0]  spc_q;
  logic [31:0] fds_q, fat_q;

  logic [31:0]        cluster_q, cluster_d;
  logic [31:0]        fbytes_q, fbytes_d;
  logic [31:0]        pos_q, pos_d;
  phase_e             phase_q, phase_d;
  logic [COUNT_W-1:0] pend_q, pend_d;
  logic [CSEC_W-1:0]  csec_q, csec_d;

  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      in_fire;

  // shared data-request datapath
  logic [31:0]        dr_cluster;
  logic [CSEC_W-1:0]  dr_csec;
  logic [31:0]        dr_prod;
  logic [31:0]        dr_sector;
  logic [31:0]        remain;
  logic [COUNT_W-1:0] dr_count;
  logic [CSEC_W-1:0]  csec_mask, csec_new;
  logic [31:0]        fat_cluster;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign csec_mask   = CSEC_W'(spc_q - 8'd1);
  assign csec_new    = pos_q[9 +: CSEC_W] & csec_mask;
  assign fat_cluster = in_data_i.fat_word & CLUSTER_MASK;

  assign dr_cluster = (in_data_i.op == OP_FAT) ? fat_cluster : cluster_q;
  assign dr_csec    = (in_data_i.op == OP_FAT) ? csec_q : csec_new;
  assign dr_prod    = (dr_cluster - 32'd2) * {24'd0, spc_q};
  assign dr_sector  = dr_prod + fds_q + {{(32-CSEC_W){1'b0}}, dr_csec};
  assign remain     = fbytes_q - pos_q;
  assign dr_count   = (remain >= {{(32-COUNT_W){1'b0}}, BEAT_MAX}) ? BEAT_MAX
                                                                    : remain[COUNT_W-1:0];

  always_comb begin
    cluster_d = cluster_q;
    fbytes_d  = fbytes_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    pend_d    = pend_q;
    csec_d    = csec_q;
    out_d     = '{kind: K_ERROR, sector_number: '0, entry_offset: '0, byte_count: '0};

    case (in_data_i.op)
      OP_OPEN: begin
        cluster_d  = in_data_i.first_cluster;
        fbytes_d   = in_data_i.file_length;
        pos_d      = '0;
        pend_d     = '0;
        csec_d     = '0;
        phase_d    = PH_READY;
        out_d.kind = K_OPENED;
      end
      OP_READ: begin
        if (phase_q == PH_READY) begin
          csec_d = csec_new;
          if (csec_new == '0 && pos_q != '0) begin
            phase_d             = PH_FAT;
            out_d.kind          = K_FATREQ;
            out_d.sector_number = fat_q + {7'd0, cluster_q[31:7]};
            out_d.entry_offset  = {cluster_q[6:0], 2'b00};
          end else if (csec_new == '0 && cluster_q <= 32'd1) begin
            out_d.kind = K_ERROR;
          end else begin
            phase_d             = PH_DATA;
            pend_d              = dr_count;
            out_d.kind          = K_DATAREQ;
            out_d.sector_number = dr_sector;
            out_d.byte_count    = dr_count;
          end
        end
      end
      OP_FAT: begin
        if (phase_q == PH_FAT) begin
          phase_d = PH_READY;
          if (in_data_i.io_ok) begin
            cluster_d = fat_cluster;
            if (fat_cluster > 32'd1) begin
              phase_d             = PH_DATA;
              pend_d              = dr_count;
              out_d.kind          = K_DATAREQ;
              out_d.sector_number = dr_sector;
              out_d.byte_count    = dr_count;
            end
          end
        end
      end
      OP_DONE: begin
        if (phase_q == PH_DATA) begin
          phase_d = PH_READY;
          if (in_data_i.io_ok) begin
            pos_d            = pos_q + {{(32-COUNT_W){1'b0}}, pend_q};
            out_d.kind       = K_DONE;
            out_d.byte_count = pend_q;
          end
        end
      end
      default: out_d.kind = K_ERROR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= 8'd1;
      fds_q <= '0;
      fat_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SPC: spc_q <= cfg_data_i[7:0];
        REG_FDS: fds_q <= cfg_data_i;
        REG_FAT: fat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_q <= '0;
      fbytes_q  <= '0;
      pos_q     <= '0;
      phase_q   <= PH_IDLE;
      pend_q    <= '0;
      csec_q    <= '0;
    end else if (in_fire) begin
      cluster_q <= cluster_d;
      fbytes_q  <= fbytes_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      pend_q    <= pend_d;
      csec_q    <= csec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == K_DATAREQ |-> out_q.byte_count <= BEAT_MAX)
    else $error("data request beat exceeds sector size");

  a_read_wrong_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.op == OP_READ && phase_q != PH_READY
    |=> out_valid_q && out_q.kind == K_ERROR && $stable(pos_q))
    else $error("read outside ready phase not rejected");

  a_open_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.op == OP_OPEN
    |=> phase_q == PH_READY && pos_q == '0 && out_q.kind == K_OPENED)
    else $error("open did not reset the walker");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> pend_q <= BEAT_MAX)
    else $error("pending count out of range");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/fccr_chain_checker.sv
`timescale 1ns / 1ps

// Watches all three channels of the chain reader, predicts every result beat
// from the accepted input beats and compares in order.
module fccr_chain_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire fccr_pkg::in_item_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire fccr_pkg::out_item_t out_data_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                end_i,
  output int                       fail_count_o
);
  import fccr_pkg::*;

  // walker copy
  logic [7:0]         spc;
  logic [31:0]        data_base;
  logic [31:0]        fat_base;
  logic [31:0]        cur_cluster;
  logic [31:0]        file_size;
  logic [31:0]        file_pos;
  phase_e             walk_phase;
  logic [COUNT_W-1:0] pend_bytes;
  logic [CSEC_W-1:0]  csec;

  out_item_t expected_replies[$];
  bit        end_seen;

  task automatic issue_data_sector(inout out_item_t r);
    logic [31:0]        remain;
    logic [COUNT_W-1:0] cnt;
    remain = file_size - file_pos;
    cnt    = BEAT_MAX;
    if (32'(cnt) > remain) cnt = remain[COUNT_W-1:0];
    r.kind          = K_DATAREQ;
    r.sector_number = (cur_cluster - 32'd2) * {24'd0, spc} + data_base + {25'd0, csec};
    r.byte_count    = cnt;
    pend_bytes      = cnt;
    walk_phase      = PH_DATA;
  endtask

  task automatic walk_step(input in_item_t b, output out_item_t r);
    r      = '0;
    r.kind = K_ERROR;
    case (b.op)
      OP_OPEN: begin
        cur_cluster = b.first_cluster;
        file_size   = b.file_length;
        file_pos    = '0;
        pend_bytes  = '0;
        csec        = '0;
        walk_phase  = PH_READY;
        r.kind      = K_OPENED;
      end
      OP_READ: begin
        if (walk_phase == PH_READY) begin
          csec = CSEC_W'(file_pos >> 9) & CSEC_W'(spc - 8'd1);
          if (csec == '0 && file_pos != '0) begin
            walk_phase      = PH_FAT;
            r.kind          = K_FATREQ;
            r.sector_number = fat_base + (cur_cluster >> 7);
            r.entry_offset  = {cur_cluster[6:0], 2'b00};
          end else if (!(csec == '0 && cur_cluster <= 32'd1)) begin
            issue_data_sector(r);
          end
        end
      end
      OP_FAT: begin
        if (walk_phase == PH_FAT) begin
          walk_phase = PH_READY;
          if (b.io_ok) begin
            cur_cluster = b.fat_word & CLUSTER_MASK;
            if (cur_cluster > 32'd1) issue_data_sector(r);
          end
        end
      end
      default: begin
        if (walk_phase == PH_DATA) begin
          walk_phase = PH_READY;
          if (b.io_ok) begin
            file_pos     = file_pos + 32'(pend_bytes);
            r.kind       = K_DONE;
            r.byte_count = pend_bytes;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      $error("result %s: expected 0x%08h, got 0x%08h", name, e, a);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      spc          = 8'd1;
      data_base    = '0;
      fat_base     = '0;
      cur_cluster  = '0;
      file_size    = '0;
      file_pos     = '0;
      walk_phase   = PH_IDLE;
      pend_bytes   = '0;
      csec         = '0;
      expected_replies.delete();
      fail_count_o = 0;
      end_seen     = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          $error("result beat 0x%h with nothing expected", out_data_i);
          fail_count_o++;
        end else begin
          want = expected_replies.pop_front();
          got  = out_data_i;
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("sector_number", want.sector_number, got.sector_number);
          check_field("entry_offset", 32'(want.entry_offset), 32'(got.entry_offset));
          check_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        walk_step(in_data_i, want);
        expected_replies.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SPC: spc       = cfg_data_i[7:0];
          REG_FDS: data_base = cfg_data_i;
          REG_FAT: fat_base  = cfg_data_i;
          default: ;
        endcase
      end
      if (end_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_replies.size() != 0) begin
          $error("%0d result beats never arrived", expected_replies.size());
          fail_count_o++;
        end
      end
    end
  end

endmodule

FILE: tb/sv/fat_cluster_chain_reader_top_tb.sv
`timescale 1ns / 1ps

module fat_cluster_chain_reader_top_tb;
  import fccr_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_BEATS = 210;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_SPC;
  logic [31:0] cfg_data_i = '0;
  logic        end_i = 1'b0;
  int          fail_count;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          in_cnt = 0;
  int          out_cnt = 0;
  out_item_t   last_out = '0;

  always #1 clk_i = ~clk_i;

  fat_cluster_chain_reader_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  fccr_chain_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .end_i        (end_i),
    .fail_count_o (fail_count)
  );

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_cnt <= in_cnt + 1;
    if (out_valid_o && out_ready_i) begin
      out_cnt  <= out_cnt + 1;
      last_out <= out_data_o;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  function automatic in_item_t beat(op_e op, logic [31:0] first, logic [31:0] len,
                                    logic [31:0] word, logic ok);
    in_item_t b;
    b.op            = op;
    b.first_cluster = first;
    b.file_length   = len;
    b.fat_word      = word;
    b.io_ok         = ok;
    return b;
  endfunction

  function automatic in_item_t noise_beat();
    return beat(op_e'($urandom_range(3)), $urandom, $urandom, $urandom,
                1'($urandom_range(1)));
  endfunction

  // all tasks start and end on a falling edge
  task automatic send(input in_item_t b);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (out_cnt != in_cnt) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] spc, input logic [31:0] fds,
                            input logic [31:0] fat, input bit poke_unused);
    settle();
    repeat (4) @(negedge clk_i);
    cfg_write(REG_SPC, {16'd0, 8'($urandom_range(255)), spc});
    cfg_write(REG_FDS, fds);
    cfg_write(REG_FAT, fat);
    if (poke_unused) cfg_write(CFG_UNUSED, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_fat_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: w[27:0] = 28'($urandom_range(1));
      1: ;
      default: w[27:0] = 28'($urandom_range(2, 1 << 20));
    endcase
    return w;
  endfunction

  task automatic walk_file();
    logic [31:0] first;
    logic [31:0] len;
    logic [31:0] word;
    logic        ok;
    int          reads;
    case ($urandom_range(19))
      0:       first = 32'($urandom_range(1));
      1, 2:    first = $urandom;
      default: first = 32'($urandom_range(2, 100000));
    endcase
    case ($urandom_range(9))
      0:       len = $urandom;
      1:       len = 32'(512 * $urandom_range(0, 8));
      default: len = 32'($urandom_range(0, 8000));
    endcase
    reads = $urandom_range(1, 14);
    send(beat(OP_OPEN, first, len, $urandom, 1'($urandom_range(1))));
    repeat (reads) begin
      send(beat(OP_READ, $urandom, $urandom, $urandom, 1'($urandom_range(1))));
      settle();
      if ($urandom_range(19) == 0) send(noise_beat());
      else if (last_out.kind == K_FATREQ) begin
        if ($urandom_range(19) == 0)
          send(beat(OP_DONE, $urandom, $urandom, $urandom, 1'($urandom_range(1))));
        word = pick_fat_word();
        ok   = ($urandom_range(15) != 0);
        send(beat(OP_FAT, $urandom, $urandom, word, ok));
        if (ok && (word & CLUSTER_MASK) > 32'd1)
          send(beat(OP_DONE, $urandom, $urandom, $urandom, $urandom_range(9) != 0));
      end else if (last_out.kind == K_DATAREQ) begin
        send(beat(OP_DONE, $urandom, $urandom, $urandom, $urandom_range(9) != 0));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0]  spc_tab[8];
    logic [31:0] fds;
    logic [31:0] fat;
    int          start;
    spc_tab = '{8'd1, 8'd2, 8'd8, 8'd128, 8'd4, 8'd3, 8'd0, 8'd255};

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset config: one sector per cluster, both bases zero
    send(beat(OP_READ, '0, '0, '0, 1'b1));                  // wrong phase
    send(beat(OP_FAT, '0, '0, '0, 1'b1));
    send(beat(OP_DONE, '0, '0, '0, 1'b1));
    send(beat(OP_OPEN, '0, '0, '0, 1'b0));
    send(beat(OP_READ, '0, '0, '0, 1'b0));                  // cluster zero
    send(beat(OP_OPEN, '1, '1, '1, 1'b1));
    send(beat(OP_READ, '1, '1, '1, 1'b1));                  // full beat, unmasked first cluster
    send(beat(OP_DONE, '1, '1, '1, 1'b1));
    send(beat(OP_READ, '1, '1, '1, 1'b1));                  // FAT request, offset 508
    send(beat(OP_READ, '1, '1, '1, 1'b1));                  // wrong phase
    send(beat(OP_FAT, '1, '1, '1, 1'b0));                   // failed FAT read
    send(beat(OP_READ, '0, '0, '0, 1'b1));                  // retry
    send(beat(OP_FAT, '0, '0, 32'hF000_0001, 1'b1));        // masked to cluster one
    send(beat(OP_READ, '0, '0, '0, 1'b1));
    send(beat(OP_FAT, '0, '0, 32'h0FFF_FFFF, 1'b1));        // end-of-chain value used
    send(beat(OP_DONE, '0, '0, '0, 1'b0));                  // failed data read
    send(beat(OP_DONE, '0, '0, '0, 1'b1));                  // wrong phase
    send(beat(OP_OPEN, 32'd5, 32'd700, '0, 1'b1));
    send(beat(OP_READ, '0, '0, '0, 1'b1));
    send(beat(OP_DONE, '0, '0, '0, 1'b1));
    send(beat(OP_READ, '0, '0, '0, 1'b1));
    send(beat(OP_FAT, '0, '0, 32'd6, 1'b1));                // short tail beat
    send(beat(OP_DONE, '0, '0, '0, 1'b1));
    send(beat(OP_READ, '0, '0, '0, 1'b1));
    send(beat(OP_FAT, '0, '0, 32'd7, 1'b1));                // end of file, zero count
    send(beat(OP_DONE, '0, '0, '0, 1'b1));

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin fds = '0;            fat = '0;            end
        2:       begin fds = '1;            fat = '1;            end
        4:       begin fds = '0;            fat = 32'hFFFF_FF00; end
        default: begin fds = $urandom;      fat = $urandom;      end
      endcase
      set_config(spc_tab[p], fds, fat, p == 5);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      start = in_cnt;
      while (in_cnt - start < PHASE_BEATS) begin
        if ($urandom_range(4) != 0) walk_file();
        else repeat ($urandom_range(1, 8)) send(noise_beat());
      end
    end

    settle();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (10) @(negedge clk_i);
    end_i <= 1'b1;
    repeat (3) @(negedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
